[rtl/jmlp_pkg.sv]
// ----------------------------------------------------------------------------
// jmlp_pkg: shared types and constants of the joystick message line parser
// Character codes, line and button limits, and the item and result records
// passed between the parser stages.
// ----------------------------------------------------------------------------
package jmlp_pkg;

	localparam int BUTTON_COUNT = 16;
	localparam int LINE_LIMIT   = 64;

	localparam int LEN_W     = $clog2(LINE_LIMIT + 1);
	localparam int POS_W     = $clog2(BUTTON_COUNT + 1);
	localparam int BTN_IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int TOK_W     = 3;
	localparam int ACC_W     = 15;
	localparam int SUM_W     = 19;
	localparam int VAL_W     = 16;
	localparam int TICK_W    = 16;

	localparam logic [TOK_W-1:0] TOK_MAX    = 3'd7;
	localparam logic [TOK_W-1:0] TOK_HEADER = 3'd1;
	localparam logic [TOK_W-1:0] TOK_BUTTON = 3'd2;
	localparam logic [TOK_W-1:0] TOK_X      = 3'd3;
	localparam logic [TOK_W-1:0] TOK_Y      = 3'd4;

	localparam logic [ACC_W-1:0] ACC_MAX = 15'd32767;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_C     = 8'h43;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic                    line_done;
		logic [BUTTON_COUNT-1:0] buttons;
		logic [VAL_W-1:0]        x_value;
		logic [VAL_W-1:0]        y_value;
	} parse_res_t;

endpackage

[rtl/jmlp_line_parser.sv]
// ----------------------------------------------------------------------------
// jmlp_line_parser: line and token state of the parser
// Holds the per-line tokenizer state and the committed button and axis
// registers; presents the state that follows the current item.
// ----------------------------------------------------------------------------
module jmlp_line_parser import jmlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  item_t      item,
	output parse_res_t res_nx
);

	logic [LEN_W-1:0]        len_q, len_nx;
	logic [TOK_W-1:0]        tok_q, tok_nx;
	logic                    inside_q, inside_nx;
	logic                    header_q, header_nx;
	logic [POS_W-1:0]        pos_q, pos_nx;
	logic [BUTTON_COUNT-1:0] pend_btn_q, pend_btn_nx;
	logic [BUTTON_COUNT-1:0] pend_mask_q, pend_mask_nx;
	logic [ACC_W-1:0]        acc_q, acc_nx;
	logic                    neg_q, neg_nx;
	logic                    stop_q, stop_nx;
	logic                    phase_q, phase_nx;
	logic [VAL_W-1:0]        pend_x_q, pend_x_nx;
	logic                    x_seen_q, x_seen_nx;
	logic [VAL_W-1:0]        pend_y_q, pend_y_nx;
	logic                    y_seen_q, y_seen_nx;
	logic [BUTTON_COUNT-1:0] btn_q, btn_nx;
	logic [VAL_W-1:0]        x_q, x_nx;
	logic [VAL_W-1:0]        y_q, y_nx;

	logic             done;
	logic             end_now;
	logic [7:0]       ch;
	logic             is_digit;
	logic [ACC_W-1:0] acc_cur;
	logic [SUM_W-1:0] sum;
	logic [VAL_W-1:0] num_val;

	// A new token starts its number from zero
	assign ch       = item.rx_byte;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign acc_cur  = inside_q ? acc_q : '0;
	assign sum      = {{(SUM_W-ACC_W){1'b0}}, acc_cur} * SUM_W'(10)
	                + {{(SUM_W-8){1'b0}}, ch - CH_ZERO};

	// Work out the state after one item
	always_comb begin
		len_nx       = len_q;
		tok_nx       = tok_q;
		inside_nx    = inside_q;
		header_nx    = header_q;
		pos_nx       = pos_q;
		pend_btn_nx  = pend_btn_q;
		pend_mask_nx = pend_mask_q;
		acc_nx       = acc_q;
		neg_nx       = neg_q;
		stop_nx      = stop_q;
		phase_nx     = phase_q;
		pend_x_nx    = pend_x_q;
		x_seen_nx    = x_seen_q;
		pend_y_nx    = pend_y_q;
		y_seen_nx    = y_seen_q;
		btn_nx       = btn_q;
		x_nx         = x_q;
		y_nx         = y_q;
		done         = 1'b0;
		end_now      = 1'b0;
		num_val      = '0;

		if (advance && item.kind == KIND_BYTE) begin
			if (ch == CH_CR) begin
				// skip carriage return
			end else if (ch == CH_LF) begin
				done    = 1'b1;
				end_now = inside_q;
			end else if (len_q < LEN_W'(LINE_LIMIT)) begin
				len_nx = len_q + 1'b1;
				if (ch == CH_NUL) begin
					// drop the rest of the line up to LF
					len_nx = LEN_W'(LINE_LIMIT);
				end else if (ch == CH_SPACE) begin
					end_now = inside_q;
				end else begin
					// open a new token on its first character
					if (!inside_q) begin
						inside_nx = 1'b1;
						if (tok_q < TOK_MAX) begin
							tok_nx = tok_q + 1'b1;
						end
						if (tok_nx == TOK_HEADER) begin
							header_nx = (ch == CH_C);
						end
						acc_nx   = '0;
						neg_nx   = 1'b0;
						stop_nx  = 1'b0;
						phase_nx = 1'b0;
					end
					if (tok_nx == TOK_BUTTON) begin
						if (pos_q < POS_W'(BUTTON_COUNT)) begin
							pend_mask_nx[pos_q[BTN_IDX_W-1:0]] = 1'b1;
							if (ch == CH_ONE) begin
								pend_btn_nx[pos_q[BTN_IDX_W-1:0]] = 1'b1;
							end
							pos_nx = pos_q + 1'b1;
						end
					end else if (tok_nx == TOK_X || tok_nx == TOK_Y) begin
						// atoi style number: blanks, sign, digits
						if (!stop_nx) begin
							if (!phase_nx && (ch == CH_TAB || ch == CH_VT || ch == CH_FF)) begin
								// skip leading blank
							end else if (!phase_nx && (ch == CH_PLUS || ch == CH_MINUS)) begin
								neg_nx   = (ch == CH_MINUS);
								phase_nx = 1'b1;
							end else if (is_digit) begin
								acc_nx   = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
								phase_nx = 1'b1;
							end else begin
								stop_nx = 1'b1;
							end
						end
					end
				end
			end
		end

		// Close the current token
		if (end_now) begin
			num_val = neg_nx ? VAL_W'(-{1'b0, acc_nx}) : {1'b0, acc_nx};
			if (tok_nx == TOK_X) begin
				pend_x_nx = num_val;
				x_seen_nx = 1'b1;
			end else if (tok_nx == TOK_Y) begin
				pend_y_nx = num_val;
				y_seen_nx = 1'b1;
			end
			inside_nx = 1'b0;
		end

		// Commit a good line, then clear the line state
		if (done) begin
			if (header_nx && tok_nx >= TOK_HEADER) begin
				if (tok_nx >= TOK_BUTTON) begin
					btn_nx = (btn_q & ~pend_mask_nx) | pend_btn_nx;
				end
				if (x_seen_nx) begin
					x_nx = -pend_x_nx;
				end
				if (y_seen_nx) begin
					y_nx = pend_y_nx;
				end
			end
			len_nx       = '0;
			tok_nx       = '0;
			inside_nx    = 1'b0;
			header_nx    = 1'b0;
			pos_nx       = '0;
			pend_btn_nx  = '0;
			pend_mask_nx = '0;
			acc_nx       = '0;
			neg_nx       = 1'b0;
			stop_nx      = 1'b0;
			phase_nx     = 1'b0;
			pend_x_nx    = '0;
			x_seen_nx    = 1'b0;
			pend_y_nx    = '0;
			y_seen_nx    = 1'b0;
		end
	end

	// Hold the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			tok_q       <= '0;
			inside_q    <= 1'b0;
			header_q    <= 1'b0;
			pos_q       <= '0;
			pend_btn_q  <= '0;
			pend_mask_q <= '0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			stop_q      <= 1'b0;
			phase_q     <= 1'b0;
			pend_x_q    <= '0;
			x_seen_q    <= 1'b0;
			pend_y_q    <= '0;
			y_seen_q    <= 1'b0;
			btn_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
		end else begin
			len_q       <= len_nx;
			tok_q       <= tok_nx;
			inside_q    <= inside_nx;
			header_q    <= header_nx;
			pos_q       <= pos_nx;
			pend_btn_q  <= pend_btn_nx;
			pend_mask_q <= pend_mask_nx;
			acc_q       <= acc_nx;
			neg_q       <= neg_nx;
			stop_q      <= stop_nx;
			phase_q     <= phase_nx;
			pend_x_q    <= pend_x_nx;
			x_seen_q    <= x_seen_nx;
			pend_y_q    <= pend_y_nx;
			y_seen_q    <= y_seen_nx;
			btn_q       <= btn_nx;
			x_q         <= x_nx;
			y_q         <= y_nx;
		end
	end

	assign res_nx.line_done = done;
	assign res_nx.buttons   = btn_nx;
	assign res_nx.x_value   = x_nx;
	assign res_nx.y_value   = y_nx;

endmodule

[rtl/jmlp_link_timer.sv]
// ----------------------------------------------------------------------------
// jmlp_link_timer: link age counter
// Counts ticks since the last completed line and compares the age against
// the programmed disconnect limit.
// ----------------------------------------------------------------------------
module jmlp_link_timer import jmlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              is_tick,
	input  logic              line_done,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_value,
	output logic              connected_nx
);

	logic [TICK_W-1:0] limit_q;
	logic [TICK_W-1:0] ticks_q, ticks_nx;
	logic [TICK_W-1:0] limit_eff;

	// Restart on a completed line, age on a tick, saturate at all ones
	always_comb begin
		ticks_nx = ticks_q;
		if (advance) begin
			if (line_done) begin
				ticks_nx = '0;
			end else if (is_tick && ticks_q != '1) begin
				ticks_nx = ticks_q + 1'b1;
			end
		end
	end

	// A zero limit acts as one
	assign limit_eff    = (limit_q == '0) ? TICK_W'(1) : limit_q;
	assign connected_nx = ticks_nx < limit_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TICK_W'(1000);
			ticks_q <= '1;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_value;
			end
			ticks_q <= ticks_nx;
		end
	end

endmodule

[rtl/joystick_message_line_parser.sv]
// ----------------------------------------------------------------------------
// joystick_message_line_parser: serial joystick message parser, top level
// Input register, line parser, link timer and output register.
// ----------------------------------------------------------------------------
// Each input transaction is a serial byte (tuser low) or a time tick (tuser
// high) and yields exactly one output transaction carrying the button and
// axis registers and the link state after that item. The block takes one
// item per clock while the output side accepts: an input register feeds
// combinational parse logic whose result is caught in an output register.
// Output valid rises once the item has passed the input register and then
// the output register. tlast marks the result of an LF that completed a
// line. The disconnect limit is written on the cfg channel, which is
// always ready; write it only while no items are in flight.
module joystick_message_line_parser import jmlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write: disconnect_ticks[15:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	input  logic [0:0]  s_axis_tuser,   // kind[0]
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // buttons[15:0], x_value[31:16],
	                                    // y_value[47:32], connected[48], zero
	output logic        m_axis_tlast    // line_done
);

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	parse_res_t res_s2;
	logic       connected_s2;
	logic       advance;
	parse_res_t res_nx;
	logic       connected_nx;

	// Move an item into the output register when that register is free
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind    <= s_axis_tuser[0];
			item_s1.rx_byte <= s_axis_tdata;
		end
	end

	jmlp_line_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.res_nx  (res_nx)
	);

	jmlp_link_timer u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.is_tick      (item_s1.kind == KIND_TICK),
		.line_done    (res_nx.line_done),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_value    (cfg_data),
		.connected_nx (connected_nx)
	);

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2       <= res_nx;
			connected_s2 <= connected_nx;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = res_s2.line_done;
	assign m_axis_tdata  = {7'd0, connected_s2, res_s2.y_value, res_s2.x_value,
	                        res_s2.buttons};

	// An empty output register never stalls the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// A held item reaches the output on the next cycle when the output was free
	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("item not moved to output register");

	// A completed line always leaves the link connected
	a_line_connects: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[48])
		else $error("completed line did not mark link connected");

	// A tick never completes a line
	a_tick_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.kind == KIND_TICK) |-> !res_nx.line_done)
		else $error("tick flagged as line end");

endmodule

[bench/joystick_result_checker.sv]
// ----------------------------------------------------------------------------
// joystick_result_checker: predicts and checks joystick parser results
// Watches the configuration, input and output channels of the parser, runs
// its own model of the line parser and link timer on every accepted input
// transaction, and compares each accepted output transaction against the
// oldest predicted result.
// ----------------------------------------------------------------------------
module joystick_result_checker import jmlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	input  logic [0:0]  s_axis_tuser,   // kind[0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,   // buttons[15:0], x_value[31:16],
	                                    // y_value[47:32], connected[48], zero
	input  logic        m_axis_tlast,   // line_done
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic                    line_done;
		logic [BUTTON_COUNT-1:0] buttons;
		logic [15:0]             x_value;
		logic [15:0]             y_value;
		logic                    connected;
		logic [6:0]              pad;
	} joy_state_t;

	// model of the line in progress
	logic [6:0]              ln_len;
	logic [TOK_W-1:0]        tok_num;
	logic                    in_tok;
	logic                    hdr_ok;
	int                      btn_pos;
	logic [BUTTON_COUNT-1:0] pend_btn;
	logic [BUTTON_COUNT-1:0] pend_mask;
	logic [15:0]             num_acc;
	logic                    num_neg;
	logic                    num_stop;
	logic                    num_phase;
	logic [15:0]             pend_x;
	logic [15:0]             pend_y;
	logic                    x_seen;
	logic                    y_seen;

	// model of the visible registers and the link timer
	logic [BUTTON_COUNT-1:0] btn_reg;
	logic [15:0]             x_reg;
	logic [15:0]             y_reg;
	logic [15:0]             tick_age;
	logic [15:0]             link_limit;

	joy_state_t predicted_states[$];
	int         fails;
	int         reported;

	assign fail_count = fails;

	// Drop all per-line state.
	task automatic clear_line();
		ln_len    = '0;
		tok_num   = '0;
		in_tok    = 1'b0;
		hdr_ok    = 1'b0;
		btn_pos   = 0;
		pend_btn  = '0;
		pend_mask = '0;
		num_acc   = '0;
		num_neg   = 1'b0;
		num_stop  = 1'b0;
		num_phase = 1'b0;
		pend_x    = '0;
		pend_y    = '0;
		x_seen    = 1'b0;
		y_seen    = 1'b0;
	endtask

	// Close the current token, latching a parsed axis value.
	task automatic close_token();
		logic [15:0] value;
		value = num_neg ? -num_acc : num_acc;
		if (tok_num == TOK_X) begin
			pend_x = value;
			x_seen = 1'b1;
		end else if (tok_num == TOK_Y) begin
			pend_y = value;
			y_seen = 1'b1;
		end
		in_tok = 1'b0;
	endtask

	// Advance the model by one item and return the resulting output state.
	task automatic parse_item(input logic kind, input logic [7:0] ch, output joy_state_t res);
		int          sum;
		logic        line_end;
		logic [15:0] limit;
		line_end = 1'b0;
		if (kind == KIND_TICK) begin
			if (tick_age != 16'hFFFF)
				tick_age = tick_age + 16'd1;
		end else if (ch == CH_CR) begin
			// carriage return is skipped entirely
		end else if (ch == CH_LF) begin
			if (in_tok)
				close_token();
			if (hdr_ok && tok_num >= TOK_HEADER) begin
				if (tok_num >= TOK_BUTTON)
					btn_reg = (btn_reg & ~pend_mask) | pend_btn;
				if (x_seen)
					x_reg = -pend_x;
				if (y_seen)
					y_reg = pend_y;
			end
			tick_age = '0;
			clear_line();
			line_end = 1'b1;
		end else if (ln_len < LINE_LIMIT) begin
			ln_len = ln_len + 7'd1;
			if (ch == CH_NUL) begin
				// NUL ends usable content: pin the length at the limit
				ln_len = 7'(LINE_LIMIT);
			end else if (ch == CH_SPACE) begin
				if (in_tok)
					close_token();
			end else begin
				if (!in_tok) begin
					in_tok = 1'b1;
					if (tok_num != TOK_MAX)
						tok_num = tok_num + 3'd1;
					if (tok_num == TOK_HEADER)
						hdr_ok = (ch == CH_C);
					num_acc   = '0;
					num_neg   = 1'b0;
					num_stop  = 1'b0;
					num_phase = 1'b0;
				end
				if (tok_num == TOK_BUTTON) begin
					if (btn_pos < BUTTON_COUNT) begin
						pend_mask[btn_pos] = 1'b1;
						if (ch == CH_ONE)
							pend_btn[btn_pos] = 1'b1;
						btn_pos++;
					end
				end else if ((tok_num == TOK_X || tok_num == TOK_Y) && !num_stop) begin
					if (!num_phase && (ch == CH_TAB || ch == CH_VT || ch == CH_FF)) begin
						// leading white space before the number is skipped
					end else if (!num_phase && (ch == CH_PLUS || ch == CH_MINUS)) begin
						num_neg   = (ch == CH_MINUS);
						num_phase = 1'b1;
					end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
						sum       = int'(num_acc) * 10 + int'(ch - CH_ZERO);
						num_acc   = (sum > 32767) ? 16'd32767 : 16'(sum);
						num_phase = 1'b1;
					end else begin
						num_stop = 1'b1;
					end
				end
			end
		end
		limit         = (link_limit == '0) ? 16'd1 : link_limit;
		res.line_done = line_end;
		res.buttons   = btn_reg;
		res.x_value   = x_reg;
		res.y_value   = y_reg;
		res.connected = (tick_age < limit);
		res.pad       = '0;
	endtask

	// Track configuration, predict on inputs, compare on outputs.
	always @(posedge clk or negedge arst_n) begin : watch
		joy_state_t got;
		joy_state_t want;
		if (!arst_n) begin
			clear_line();
			btn_reg    = '0;
			x_reg      = '0;
			y_reg      = '0;
			tick_age   = 16'hFFFF;
			link_limit = 16'd1000;
			predicted_states.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				link_limit = cfg_data;

			// compare the output transaction before adding this edge's input
			if (m_axis_tvalid && m_axis_tready) begin
				got.line_done = m_axis_tlast;
				got.buttons   = m_axis_tdata[15:0];
				got.x_value   = m_axis_tdata[31:16];
				got.y_value   = m_axis_tdata[47:32];
				got.connected = m_axis_tdata[48];
				got.pad       = m_axis_tdata[55:49];
				if (predicted_states.size() == 0) begin
					fails++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result: done=%0b btn=%h x=%0d y=%0d conn=%0b",
							got.line_done, got.buttons, $signed(got.x_value),
							$signed(got.y_value), got.connected);
					end
				end else begin
					want = predicted_states.pop_front();
					if (got.line_done !== want.line_done || got.buttons !== want.buttons ||
						got.x_value !== want.x_value || got.y_value !== want.y_value ||
						got.connected !== want.connected || got.pad !== want.pad) begin
						fails++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: expected done=%0b btn=%h x=%0d y=%0d conn=%0b pad=%h",
								want.line_done, want.buttons, $signed(want.x_value),
								$signed(want.y_value), want.connected, want.pad);
							$display("          actual   done=%0b btn=%h x=%0d y=%0d conn=%0b pad=%h",
								got.line_done, got.buttons, $signed(got.x_value),
								$signed(got.y_value), got.connected, got.pad);
						end
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				parse_item(s_axis_tuser[0], s_axis_tdata, want);
				predicted_states.push_back(want);
			end
			pending <= predicted_states.size();
		end
	end

endmodule

[bench/joystick_message_line_parser_tb.sv]
// ----------------------------------------------------------------------------
// joystick_message_line_parser_tb: stimulus and verdict for the line parser
// Sends a short directed set of lines and ticks, then random message lines,
// blank lines, noise and tick runs under several disconnect limits and
// back-pressure settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module joystick_message_line_parser_tb;
	import jmlp_pkg::*;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	int fail_count;
	int pending;
	int src_idle  = 0;
	int sink_idle = 0;
	int items_sent = 0;

	always #5 clk = ~clk;

	joystick_message_line_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	joystick_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Stall the output side at random.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle);
	end

	// Send one item, with random idle cycles ahead of it.
	task automatic push_item(input logic kind, input logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		foreach (q[i])
			push_item(KIND_BYTE, q[i]);
	endtask

	// Hold the input until every predicted result has arrived.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0]  text[$];
		logic [15:0] limits[6];
		logic [7:0]  c;
		int          shape;
		int          ntok;
		int          run_max;
		int          target;
		int          r;

		limits = '{16'd1, 16'd0, 16'd65535, 16'd7, 16'd40, 16'd3};
		src_idle  = 6;
		sink_idle = 59;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick straight after reset: age already saturated
		push_item(KIND_TICK, 8'hFF);
		// empty line connects the link
		text = {CH_LF};
		send_bytes(text);
		// full message with signs, CR and an extra token
		text = {CH_C, CH_SPACE, CH_ONE, CH_SPACE, CH_MINUS, CH_ZERO + 8'd5, CH_SPACE,
			CH_PLUS, CH_ZERO + 8'd7, CH_SPACE, CH_NINE, CH_CR, CH_LF};
		send_bytes(text);
		// tick whose data looks like LF must not end a line
		push_item(KIND_TICK, CH_LF);
		// NUL drops the rest of the line
		text = {CH_C, CH_NUL, CH_SPACE, CH_ONE, CH_LF};
		send_bytes(text);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_limit(limits[ph]);
			src_idle  = (ph < 2) ? 6 : (ph < 4) ? 59 : 0;
			sink_idle = (ph < 2) ? 59 : (ph < 4) ? 6 : 0;
			run_max   = (limits[ph] > 16'd50) ? 50 : int'(limits[ph]) + 3;
			target    = items_sent + 160;
			while (items_sent < target) begin
				text.delete();
				shape = $urandom_range(99);
				if (shape < 8) begin
					// raw noise, may contain LF or CR anywhere
					repeat ($urandom_range(1, 12))
						text.push_back(8'($urandom_range(255)));
				end else if (shape < 12) begin
					// blank line
					repeat ($urandom_range(0, 3))
						text.push_back(CH_SPACE);
				end else begin
					// header token, mostly valid
					if (shape < 20) begin
						c = 8'($urandom_range(33, 126));
						if (c == CH_C)
							c = CH_C + 8'd1;
						text.push_back(c);
					end else begin
						text.push_back(CH_C);
					end
					repeat ($urandom_range(0, 2))
						text.push_back(8'($urandom_range(33, 126)));
					ntok = $urandom_range(0, 5);
					for (int t = 0; t < ntok; t++) begin
						repeat ($urandom_range(1, 3))
							text.push_back(($urandom_range(19) == 0) ? CH_CR : CH_SPACE);
						if (t == 0) begin
							// button token, sometimes longer than the button count
							repeat ($urandom_range(1, 20)) begin
								r = $urandom_range(99);
								text.push_back((r < 45) ? CH_ONE : (r < 90) ? CH_ZERO :
									8'($urandom_range(33, 126)));
							end
						end else begin
							// number token: white space, sign, digits, junk
							r = $urandom_range(99);
							if (r < 20) begin
								repeat ($urandom_range(1, 2)) begin
									case ($urandom_range(2))
										0: text.push_back(CH_TAB);
										1: text.push_back(CH_VT);
										default: text.push_back(CH_FF);
									endcase
								end
							end
							r = $urandom_range(99);
							if (r < 35)
								text.push_back(CH_MINUS);
							else if (r < 50)
								text.push_back(CH_PLUS);
							repeat (($urandom_range(9) == 0) ? $urandom_range(0, 8) :
								$urandom_range(1, 5))
								text.push_back(CH_ZERO + 8'($urandom_range(9)));
							if ($urandom_range(6) == 0) begin
								text.push_back(($urandom_range(1) == 0) ? CH_MINUS :
									8'($urandom_range(33, 126)));
								text.push_back(CH_ZERO + 8'($urandom_range(9)));
							end
						end
					end
					// overlong tail past the line limit
					if ($urandom_range(9) == 0) begin
						repeat ($urandom_range(40, 70))
							text.push_back(($urandom_range(3) == 0) ? CH_SPACE :
								8'($urandom_range(33, 126)));
					end
					// NUL in the middle, followed by more content
					if ($urandom_range(19) == 0) begin
						text.push_back(CH_NUL);
						text.push_back(CH_SPACE);
						text.push_back(CH_ONE);
					end
					repeat ($urandom_range(0, 2))
						text.push_back(CH_SPACE);
				end
				if ($urandom_range(2) == 0)
					text.push_back(CH_CR);
				text.push_back(CH_LF);
				send_bytes(text);

				// age the link, sometimes past the disconnect limit
				repeat (($urandom_range(99) < 15) ? $urandom_range(0, run_max) :
					$urandom_range(0, 2))
					push_item(KIND_TICK, 8'($urandom_range(255)));
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Abort a hung run.
	initial begin : watchdog
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule
